// ----- rtl/qte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, constants and step functions of the quaternion to euler core
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  localparam int CW         = 36;
  localparam int ZW         = 37;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 31;
  localparam int DEG_STAGES = 3;
  localparam int FRONT_LEN  = DIV_STEPS + 2 + SQRT_STEPS;
  localparam int NUM_STAGES = 2 + FRONT_LEN + CORDIC_STEPS + 1 + DEG_STAGES;

  localparam logic [32:0] NORM_THRESH =
    33'((64'd1 << (2 * QUAT_FRAC_BITS)) / 64'd1000000);
  localparam logic [47:0] QPI_Q32   = 48'd3373259426;
  localparam logic [47:0] HALF_QPI  = QPI_Q32 / 48'd2;
  // floor(2^47 / (pi/4 in q32))
  localparam logic [15:0] DEG_RECIP = 16'd41721;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(64'd4 * 64'd3373259426);
  localparam logic [47:0] DEG_SCALE = 48'(45 << ANGLE_FRAC_BITS);
  localparam logic signed [17:0] HALF_TURN = 18'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [17:0] QUARTER   = 18'(90 << ANGLE_FRAC_BITS);
  localparam logic [30:0] ONE_Q30 = 31'(64'd1 << 30);
  localparam logic [60:0] ONE_Q60 = 61'(64'd1 << 60);

  typedef struct packed {
    logic signed [31:0] rr;
    logic signed [31:0] ii;
    logic signed [31:0] jj;
    logic signed [31:0] kk;
    logic signed [31:0] ij;
    logic signed [31:0] kr;
    logic signed [31:0] jk;
    logic signed [31:0] ir;
    logic signed [31:0] jr;
    logic signed [31:0] ik;
  } prod_t;

  typedef struct packed {
    logic               ok;
    logic [32:0]        norm;
    logic signed [33:0] num;
    logic signed [CW-1:0] yx;
    logic signed [CW-1:0] yy;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
  } sum_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } crd_t;

  typedef struct packed {
    logic ok;
    crd_t yaw;
    crd_t roll;
  } side_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [32:0] norm;
    logic [30:0] q;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [30:0] an;
    logic        neg;
    logic [60:0] sq;
  } sq_t;

  typedef struct packed {
    logic [60:0] v;
    logic [60:0] res;
    logic [30:0] an;
    logic        neg;
  } sqr_t;

  typedef struct packed {
    logic ok;
    crd_t yaw;
    crd_t pitch;
    crd_t roll;
  } cst_t;

  typedef struct packed {
    logic [47:0] n;
    logic [15:0] q;
    logic        neg;
    logic        zero;
  } deg_t;

  typedef struct packed {
    logic ok;
    deg_t yaw;
    deg_t pitch;
    deg_t roll;
  } dst_t;

  function automatic logic signed [ZW-1:0] atan_q32(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(64'd3373259426);
      1:       v = ZW'(64'd1991351318);
      2:       v = ZW'(64'd1052175346);
      3:       v = ZW'(64'd534100635);
      4:       v = ZW'(64'd268086748);
      5:       v = ZW'(64'd134174063);
      6:       v = ZW'(64'd67103403);
      7:       v = ZW'(64'd33553749);
      8:       v = ZW'(64'd16777131);
      9:       v = ZW'(64'd8388597);
      10:      v = ZW'(64'd4194303);
      11:      v = ZW'(64'd2097152);
      12:      v = ZW'(64'd1048576);
      13:      v = ZW'(64'd524288);
      14:      v = ZW'(64'd262144);
      15:      v = ZW'(64'd131072);
      default: v = ZW'(64'd2 ** 32 >> idx);
    endcase
    return v;
  endfunction

  function automatic crd_t crd_prep(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    crd_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = (y >= 0) ? PI_Z : -PI_Z;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  function automatic crd_t crd_step(input crd_t c, input int idx);
    crd_t o;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x >>> idx;
    ys = c.y >>> idx;
    o.zero = c.zero;
    if (c.y >= 0) begin
      o.x = c.x + ys;
      o.y = c.y - xs;
      o.z = c.z + atan_q32(idx);
    end else begin
      o.x = c.x - ys;
      o.y = c.y + xs;
      o.z = c.z - atan_q32(idx);
    end
    return o;
  endfunction

  function automatic deg_t deg_init(input crd_t c);
    deg_t d;
    logic [ZW-1:0] mag;
    mag    = (c.z < 0) ? ZW'(-c.z) : ZW'(c.z);
    d.n    = 48'(mag) * DEG_SCALE + HALF_QPI;
    d.q    = '0;
    d.neg  = c.z < 0;
    d.zero = c.zero;
    return d;
  endfunction

  // quotient estimate from the upper bits, low by at most one
  function automatic deg_t deg_est(input deg_t d);
    deg_t o;
    logic [47:0] prod;
    prod = 48'(d.n[46:15]) * 48'(DEG_RECIP);
    o    = d;
    o.q  = prod[47:32];
    return o;
  endfunction

  function automatic deg_t deg_rem(input deg_t d);
    deg_t o;
    o   = d;
    o.n = d.n - 48'(d.q) * QPI_Q32;
    return o;
  endfunction

  function automatic deg_t deg_fix(input deg_t d);
    deg_t o;
    o = d;
    if (d.n >= QPI_Q32) begin
      o.q = d.q + 16'd1;
    end
    return o;
  endfunction

  function automatic logic signed [17:0] deg_value(input deg_t d);
    logic signed [17:0] v;
    v = d.neg ? -$signed({2'b00, d.q}) : $signed({2'b00, d.q});
    if (d.zero) begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] wrap_half(input logic signed [17:0] v);
    logic signed [17:0] w;
    w = v;
    if (w > HALF_TURN) begin
      w = w - 18'(2 * 23040);
    end
    if (w <= -HALF_TURN) begin
      w = w + 18'(2 * 23040);
    end
    return w[15:0];
  endfunction

endpackage

// ----- rtl/quaternion_to_euler_angles_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// unit quaternion in q14 to yaw, pitch and roll in 1/128 degree, pipelined
//
// channel   dir  tdata (low bit up)                     tuser
// in_       in   quat_real, quat_i, quat_j, quat_k      -
// out_      out  yaw, pitch, roll, pad                   valid_res
//
// one transfer per cycle in and out while the output is not stalled
// latency set by the bit-serial divider and square root stages of the pitch path
// a stalled output freezes every stage, nothing is dropped or repeated
// rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [qte_pkg::IN_TDATA_W-1:0]     in_tdata,   // quat_real, quat_i, quat_j, quat_k
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qte_pkg::OUT_TDATA_W-1:0]    out_tdata,  // yaw, pitch, roll, zero pad
  output logic                               out_tuser   // valid_res
);
  import qte_pkg::*;

  logic en;
  logic [NUM_STAGES-1:0] vld_r;
  logic out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic out_tuser_r;

  logic signed [15:0] qr, qi, qj, qk;
  prod_t p_nxt, p_r;
  sum_t  s_nxt, s_r;
  side_t side_r [FRONT_LEN];
  div_t  div_r [DIV_STEPS];
  sq_t   sq_r;
  sqr_t  vin_r;
  sqr_t  sqr_r [SQRT_STEPS];
  cst_t  crd_r [CORDIC_STEPS];
  cst_t  crd_in;
  dst_t  dm_r;
  dst_t  dq_r, dr_r, dc_r;
  logic signed [17:0] pv;
  logic signed [14:0] pitch_o;
  logic signed [15:0] yaw_o, roll_o;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[NUM_STAGES-2:0], in_tvalid};
      out_tvalid_r <= vld_r[NUM_STAGES-1];
    end
  end

  // products
  always_comb begin
    qr = in_tdata[15:0];
    qi = in_tdata[31:16];
    qj = in_tdata[47:32];
    qk = in_tdata[63:48];
    p_nxt.rr = qr * qr;
    p_nxt.ii = qi * qi;
    p_nxt.jj = qj * qj;
    p_nxt.kk = qk * qk;
    p_nxt.ij = qi * qj;
    p_nxt.kr = qk * qr;
    p_nxt.jk = qj * qk;
    p_nxt.ir = qi * qr;
    p_nxt.jr = qj * qr;
    p_nxt.ik = qi * qk;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  // sums
  always_comb begin
    s_nxt.norm = 33'($unsigned(p_r.rr)) + 33'($unsigned(p_r.ii))
               + 33'($unsigned(p_r.jj)) + 33'($unsigned(p_r.kk));
    s_nxt.ok   = s_nxt.norm > NORM_THRESH;
    s_nxt.num  = (34'(p_r.jr) - 34'(p_r.ik)) <<< 1;
    s_nxt.yy   = (CW'(p_r.ij) + CW'(p_r.kr)) <<< 1;
    s_nxt.yx   = CW'(p_r.ii) - CW'(p_r.jj) - CW'(p_r.kk) + CW'(p_r.rr);
    s_nxt.ry   = (CW'(p_r.jk) + CW'(p_r.ir)) <<< 1;
    s_nxt.rx   = CW'(p_r.rr) + CW'(p_r.kk) - CW'(p_r.ii) - CW'(p_r.jj);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  // yaw and roll vectors wait beside the pitch divider and square root
  for (genvar g = 0; g < FRONT_LEN; g++) begin : g_side
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[g].ok   <= s_r.ok;
          side_r[g].yaw  <= crd_prep(s_r.yx, s_r.yy);
          side_r[g].roll <= crd_prep(s_r.rx, s_r.ry);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[g] <= side_r[g-1];
        end
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    div_t d_in, d_nxt;
    logic [33:0] t;
    always_comb begin
      if (g == 0) begin
        d_in.rem  = s_r.num[33] ? 34'(-s_r.num) : 34'(s_r.num);
        d_in.norm = s_r.norm;
        d_in.q    = '0;
        d_in.neg  = s_r.num[33];
        t         = d_in.rem;
      end else begin
        d_in = div_r[(g == 0) ? 0 : g-1];
        t    = {d_in.rem[32:0], 1'b0};
      end
      d_nxt = d_in;
      if (t >= {1'b0, d_in.norm}) begin
        d_nxt.rem = t - {1'b0, d_in.norm};
        d_nxt.q   = {d_in.q[29:0], 1'b1};
      end else begin
        d_nxt.rem = t;
        d_nxt.q   = {d_in.q[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[g] <= d_nxt;
      end
    end
  end

  // clamp and square
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r.an  <= (div_r[DIV_STEPS-1].q > ONE_Q30) ? ONE_Q30 : div_r[DIV_STEPS-1].q;
      sq_r.neg <= div_r[DIV_STEPS-1].neg;
      sq_r.sq  <= 61'((62'(div_r[DIV_STEPS-1].q > ONE_Q30 ? ONE_Q30 : div_r[DIV_STEPS-1].q))
                 * (62'(div_r[DIV_STEPS-1].q > ONE_Q30 ? ONE_Q30 : div_r[DIV_STEPS-1].q)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vin_r.v   <= ONE_Q60 - sq_r.sq;
      vin_r.res <= '0;
      vin_r.an  <= sq_r.an;
      vin_r.neg <= sq_r.neg;
    end
  end

  // bit-pair square root, one result bit per stage
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    sqr_t r_in, r_nxt;
    logic [61:0] t;
    logic [60:0] bitv;
    always_comb begin
      r_in  = (g == 0) ? vin_r : sqr_r[(g == 0) ? 0 : g-1];
      bitv  = 61'(1) << (60 - 2 * g);
      t     = {1'b0, r_in.res} + {1'b0, bitv};
      r_nxt = r_in;
      if ({1'b0, r_in.v} >= t) begin
        r_nxt.v   = r_in.v - t[60:0];
        r_nxt.res = (r_in.res >> 1) + bitv;
      end else begin
        r_nxt.res = r_in.res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqr_r[g] <= r_nxt;
      end
    end
  end

  // three cordic vectoring units side by side
  always_comb begin
    crd_in.ok         = side_r[FRONT_LEN-1].ok;
    crd_in.yaw        = side_r[FRONT_LEN-1].yaw;
    crd_in.roll       = side_r[FRONT_LEN-1].roll;
    crd_in.pitch.x    = CW'(sqr_r[SQRT_STEPS-1].res);
    crd_in.pitch.y    = sqr_r[SQRT_STEPS-1].neg ? -CW'(sqr_r[SQRT_STEPS-1].an)
                                                :  CW'(sqr_r[SQRT_STEPS-1].an);
    crd_in.pitch.z    = '0;
    crd_in.pitch.zero = 1'b0;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_crd
    cst_t c_in;
    assign c_in = (g == 0) ? crd_in : crd_r[(g == 0) ? 0 : g-1];
    always_ff @(posedge clk) begin
      if (en) begin
        crd_r[g].ok    <= c_in.ok;
        crd_r[g].yaw   <= crd_step(c_in.yaw, g);
        crd_r[g].pitch <= crd_step(c_in.pitch, g);
        crd_r[g].roll  <= crd_step(c_in.roll, g);
      end
    end
  end

  // radians to degrees, scale then divide by pi/4 with a reciprocal estimate
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r.ok    <= crd_r[CORDIC_STEPS-1].ok;
      dm_r.yaw   <= deg_init(crd_r[CORDIC_STEPS-1].yaw);
      dm_r.pitch <= deg_init(crd_r[CORDIC_STEPS-1].pitch);
      dm_r.roll  <= deg_init(crd_r[CORDIC_STEPS-1].roll);
    end
  end

  // estimate, remainder, one correction step
  always_ff @(posedge clk) begin
    if (en) begin
      dq_r.ok    <= dm_r.ok;
      dq_r.yaw   <= deg_est(dm_r.yaw);
      dq_r.pitch <= deg_est(dm_r.pitch);
      dq_r.roll  <= deg_est(dm_r.roll);
      dr_r.ok    <= dq_r.ok;
      dr_r.yaw   <= deg_rem(dq_r.yaw);
      dr_r.pitch <= deg_rem(dq_r.pitch);
      dr_r.roll  <= deg_rem(dq_r.roll);
      dc_r.ok    <= dr_r.ok;
      dc_r.yaw   <= deg_fix(dr_r.yaw);
      dc_r.pitch <= deg_fix(dr_r.pitch);
      dc_r.roll  <= deg_fix(dr_r.roll);
    end
  end

  // wrap, clamp and zero for small norm
  always_comb begin
    yaw_o  = wrap_half(deg_value(dc_r.yaw));
    roll_o = wrap_half(deg_value(dc_r.roll));
    pv     = deg_value(dc_r.pitch);
    if (pv > QUARTER) begin
      pv = QUARTER;
    end
    if (pv < -QUARTER) begin
      pv = -QUARTER;
    end
    pitch_o = pv[14:0];
    if (!dc_r.ok) begin
      yaw_o   = '0;
      roll_o  = '0;
      pitch_o = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {1'b0, roll_o, pitch_o, yaw_o};
      out_tuser_r <= dc_r.ok;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid result carries nonzero angles");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd11520) &&
                   ($signed(out_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

  a_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) != -16'sd23040) &&
                   ($signed(out_tdata[46:31]) != -16'sd23040))
    else $error("angle not wrapped to half turn");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transfer lost at pipeline entry");

endmodule
